// ===== src/pwe_pkg.sv =====
// ----------------------------------------------------------------------------
// pwe_pkg
// Shared constants, codes and pipeline record types of the periodic waveform
// evaluation unit.
// ----------------------------------------------------------------------------
package pwe_pkg;

    // Fixed-point format: FRAC_BITS fraction bits, ONE stands for 1.0
    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = FRAC_BITS + 1;
    localparam int DUTY_W    = FRAC_BITS + 1;
    localparam int PHASE_W   = 32;
    localparam int OUT_W     = 17;
    localparam int TYPE_W    = 2;

    localparam logic [VAL_W-1:0] ONE      = VAL_W'(1) << FRAC_BITS;
    localparam logic [VAL_W-1:0] HALF     = VAL_W'(1) << (FRAC_BITS - 1);
    localparam logic [VAL_W-1:0] VAL_ZERO = '0;

    // Divider split: a few restoring steps per register stage
    localparam int BITS_PER_STAGE = 4;
    localparam int DIV_STAGES     = (FRAC_BITS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
    localparam int Q_W            = DIV_STAGES * BITS_PER_STAGE;
    localparam int Q_EXTRA        = Q_W - FRAC_BITS;

    // Shape codes
    typedef enum logic [TYPE_W-1:0] {
        SHAPE_SQUARE   = 2'd0,
        SHAPE_TRIANGLE = 2'd1,
        SHAPE_SAWTOOTH = 2'd2
    } shape_t;

    // One divider lane: partial remainder, divisor, quotient so far
    typedef struct packed {
        logic             en;
        logic [VAL_W-1:0] rem;
        logic [VAL_W-1:0] div;
        logic [Q_W-1:0]   quo;
    } div_lane_t;

    // Record carried down the pipeline for one beat
    typedef struct packed {
        logic [VAL_W-1:0] base;
        div_lane_t        lane_a;
        div_lane_t        lane_b;
    } pipe_rec_t;

endpackage

// ===== src/pwe_in_if.sv =====
// ----------------------------------------------------------------------------
// pwe_in_if
// Request channel: shape code, duty enable, phase and duty per beat.
// ----------------------------------------------------------------------------
interface pwe_in_if import pwe_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic [TYPE_W-1:0]         req_type;
    logic                      use_duty;
    logic signed [PHASE_W-1:0] phase;
    logic [DUTY_W-1:0]         duty;

    modport source (
        output valid,
        output req_type,
        output use_duty,
        output phase,
        output duty,
        input  ready
    );

    modport sink (
        input  valid,
        input  req_type,
        input  use_duty,
        input  phase,
        input  duty,
        output ready
    );

endinterface

// ===== src/pwe_out_if.sv =====
// ----------------------------------------------------------------------------
// pwe_out_if
// Result channel: one waveform value per beat.
// ----------------------------------------------------------------------------
interface pwe_out_if import pwe_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] wave_value;

    modport source (
        output valid,
        output wave_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  wave_value,
        output ready
    );

endinterface

// ===== src/periodic_waveform_eval_unit.sv =====
// ----------------------------------------------------------------------------
// periodic_waveform_eval_unit
// Square, triangle and sawtooth waveform evaluation with optional duty cycle.
// ----------------------------------------------------------------------------
// The unit takes one request beat per clock while the sink keeps up and returns
// one wave_value beat per request, in order, through one decode stage,
// DIV_STAGES restoring divider stages of BITS_PER_STAGE quotient bits each,
// and the output register.
// Throughput is one beat per cycle; the divider lanes are fully pipelined,
// so the rate is set only by the sink: a stalled output holds every stage
// and the request channel drops ready only once the pipeline is full.
module periodic_waveform_eval_unit import pwe_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    pwe_in_if.sink    req_ch,
    pwe_out_if.source rsp_ch
);

    logic      stg_valid [DIV_STAGES+1];
    logic      stg_ready [DIV_STAGES+1];
    pipe_rec_t stg_rec   [DIV_STAGES+1];

    // Decode
    pwe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_ch    (req_ch),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_rec   (stg_rec[0])
    );

    // Divider stages
    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        pwe_div_stage u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[s]),
            .in_ready  (stg_ready[s]),
            .in_rec    (stg_rec[s]),
            .out_valid (stg_valid[s+1]),
            .out_ready (stg_ready[s+1]),
            .out_rec   (stg_rec[s+1])
        );
    end

    // Combine and hold the result
    pwe_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stg_valid[DIV_STAGES]),
        .in_ready (stg_ready[DIV_STAGES]),
        .in_rec   (stg_rec[DIV_STAGES]),
        .rsp_ch   (rsp_ch)
    );

endmodule

// ===== src/pwe_front.sv =====
// ----------------------------------------------------------------------------
// pwe_front
// Decode stage: extract the phase fraction, saturate the duty, settle the
// shapes that need no division and load the divider lanes.
// ----------------------------------------------------------------------------
module pwe_front import pwe_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    pwe_in_if.sink    req_ch,
    output logic      out_valid,
    input  logic      out_ready,
    output pipe_rec_t out_rec
);

    logic             valid_reg;
    pipe_rec_t        rec_reg;
    pipe_rec_t        rec_next;

    logic [VAL_W-1:0] t_val;
    logic [VAL_W-1:0] u_val;
    logic [VAL_W-1:0] d_sat;
    logic [VAL_W-1:0] d_inv;
    logic [VAL_W-1:0] d_saw;
    logic [VAL_W-1:0] sq_lim;
    logic [VAL_W-1:0] twice;

    // Take the fraction and its complement modulo one
    assign t_val  = VAL_W'(req_ch.phase[FRAC_BITS-1:0]);
    assign u_val  = VAL_W'(FRAC_BITS'(ONE - t_val));
    assign d_sat  = (req_ch.duty > DUTY_W'(ONE)) ? ONE : VAL_W'(req_ch.duty);
    assign d_inv  = ONE - d_sat;
    assign d_saw  = req_ch.use_duty ? d_sat : ONE;
    assign sq_lim = req_ch.use_duty ? d_sat : HALF;
    assign twice  = VAL_W'({req_ch.phase[FRAC_BITS-1:0], 1'b0});

    // Decode the shape into a base value and divider work
    always_comb
    begin
        rec_next.base       = VAL_ZERO;
        rec_next.lane_a.en  = 1'b0;
        rec_next.lane_a.rem = VAL_ZERO;
        rec_next.lane_a.div = ONE;
        rec_next.lane_a.quo = '0;
        rec_next.lane_b.en  = 1'b0;
        rec_next.lane_b.rem = VAL_ZERO;
        rec_next.lane_b.div = ONE;
        rec_next.lane_b.quo = '0;
        case (req_ch.req_type)
            SHAPE_SQUARE:
            begin
                rec_next.base = (t_val < sq_lim) ? ONE : VAL_ZERO;
            end
            SHAPE_TRIANGLE:
            begin
                if (req_ch.use_duty)
                begin
                    if (d_sat != VAL_ZERO && t_val < d_sat)
                    begin
                        rec_next.lane_a.en  = 1'b1;
                        rec_next.lane_a.rem = t_val;
                        rec_next.lane_a.div = d_sat;
                    end
                    if (d_inv != VAL_ZERO && u_val < d_inv)
                    begin
                        rec_next.lane_b.en  = 1'b1;
                        rec_next.lane_b.rem = u_val;
                        rec_next.lane_b.div = d_inv;
                    end
                end
                else
                begin
                    rec_next.base = (twice >= ONE) ? (twice - ONE) : (ONE - twice);
                end
            end
            SHAPE_SAWTOOTH:
            begin
                if (d_saw == VAL_ZERO || t_val > d_saw)
                begin
                    rec_next.base = VAL_ZERO;
                end
                else if (t_val == d_saw || (t_val == VAL_ZERO && d_saw == ONE))
                begin
                    // Full scale at the ramp top and at phase zero with full duty
                    rec_next.base = ONE;
                end
                else
                begin
                    rec_next.lane_a.en  = 1'b1;
                    rec_next.lane_a.rem = t_val;
                    rec_next.lane_a.div = d_saw;
                end
            end
            default:
            begin
                rec_next.base = VAL_ZERO;
            end
        endcase
    end

    // Advance when the stage is empty or the next stage takes the beat
    assign req_ch.ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req_ch.ready)
        begin
            valid_reg <= req_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ch.ready && req_ch.valid)
        begin
            rec_reg <= rec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rec   = rec_reg;

endmodule

// ===== src/pwe_div_stage.sv =====
// ----------------------------------------------------------------------------
// pwe_div_stage
// One divider stage: a few restoring compare-subtract steps on both lanes,
// followed by the pipeline register.
// ----------------------------------------------------------------------------
module pwe_div_stage import pwe_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  pipe_rec_t in_rec,
    output logic      out_valid,
    input  logic      out_ready,
    output pipe_rec_t out_rec
);

    logic      valid_reg;
    pipe_rec_t rec_reg;
    pipe_rec_t rec_next;

    // Shift in one quotient bit per step; numerator low bits are all zero
    function automatic div_lane_t div_steps(input div_lane_t lane);
        div_lane_t          res;
        logic [VAL_W:0]     trial;
        logic [VAL_W:0]     dvs;
        res = lane;
        dvs = {1'b0, lane.div};
        for (int i = 0; i < BITS_PER_STAGE; i++)
        begin
            trial = {res.rem, 1'b0};
            if (trial >= dvs)
            begin
                res.rem = VAL_W'(trial - dvs);
                res.quo = {res.quo[Q_W-2:0], 1'b1};
            end
            else
            begin
                res.rem = VAL_W'(trial);
                res.quo = {res.quo[Q_W-2:0], 1'b0};
            end
        end
        return res;
    endfunction

    always_comb
    begin
        rec_next        = in_rec;
        rec_next.lane_a = div_steps(in_rec.lane_a);
        rec_next.lane_b = div_steps(in_rec.lane_b);
    end

    // Hold on stall, advance otherwise
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rec_reg <= rec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rec   = rec_reg;

endmodule

// ===== src/pwe_back.sv =====
// ----------------------------------------------------------------------------
// pwe_back
// Output stage: add the base value and the enabled quotients and hold the
// result in the output register.
// ----------------------------------------------------------------------------
module pwe_back import pwe_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  pipe_rec_t in_rec,
    pwe_out_if.source rsp_ch
);

    logic             valid_reg;
    logic [OUT_W-1:0] value_reg;
    logic [OUT_W-1:0] value_next;

    logic [Q_W-1:0]   qa_full;
    logic [Q_W-1:0]   qb_full;
    logic [VAL_W:0]   qa;
    logic [VAL_W:0]   qb;
    logic [VAL_W:0]   sum;

    // Drop the surplus quotient bits of the last stage
    assign qa_full = in_rec.lane_a.quo >> Q_EXTRA;
    assign qb_full = in_rec.lane_b.quo >> Q_EXTRA;
    assign qa      = in_rec.lane_a.en ? (VAL_W+1)'(qa_full[FRAC_BITS-1:0]) : '0;
    assign qb      = in_rec.lane_b.en ? (VAL_W+1)'(qb_full[FRAC_BITS-1:0]) : '0;
    assign sum     = (VAL_W+1)'(in_rec.base) + qa + qb;

    assign value_next = OUT_W'(sum);

    // Output register: take a new beat when empty or when the sink takes ours
    assign in_ready = !valid_reg || rsp_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            value_reg <= value_next;
        end
    end

    assign rsp_ch.valid      = valid_reg;
    assign rsp_ch.wave_value = value_reg;

endmodule

// ===== verif/periodic_waveform_eval_unit_tb.sv =====
// ----------------------------------------------------------------------------
// periodic_waveform_eval_unit_tb
// Self-checking bench for the periodic waveform evaluation unit. Directed
// beats hit the shape boundaries, zero divisors, duty saturation and the
// unused shape code. Random beats follow with idle cycles on both channels,
// a stretch with no idling, and a long output hold-off that fills the
// pipeline. Every accepted request is scored against an in-bench wave
// calculator, and results are checked in order.
// ----------------------------------------------------------------------------
module periodic_waveform_eval_unit_tb;
    import pwe_pkg::*;

    localparam logic [TYPE_W-1:0] SHAPE_UNUSED = 2'd3;
    localparam int IDLE_PCT       = 30;
    localparam int STALL_LIMIT    = 1000;
    localparam int DRAIN_LIMIT    = 200;
    localparam int SETTLE_CYCLES  = DIV_STAGES + 6;
    localparam int HOLD_OFF_LEN   = 200;

    typedef struct packed {
        logic [TYPE_W-1:0]  req_type;
        logic               use_duty;
        logic [PHASE_W-1:0] phase;
        logic [DUTY_W-1:0]  duty;
    } wave_req_t;

    logic clk = 1'b0;
    logic rst_n;

    pwe_in_if  req_bus ();
    pwe_out_if rsp_bus ();

    periodic_waveform_eval_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .req_ch (req_bus.sink),
        .rsp_ch (rsp_bus.source)
    );

    // Expected wave values, oldest first
    logic [OUT_W-1:0] pending_waves[$];
    int               error_count   = 0;
    int               tx_idle_pct   = IDLE_PCT;
    int               rx_idle_pct   = IDLE_PCT;
    int               rx_hold_cycles = 0;

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Wave calculator
    // ------------------------------------------------------------------------
    function automatic logic [OUT_W-1:0] calc_wave(input wave_req_t r);
        logic [63:0] one_v;
        logic [63:0] t;
        logic [63:0] d;
        logic [63:0] u;
        logic [63:0] d2;
        logic [63:0] span;
        logic [63:0] twice;
        logic [63:0] res;
        one_v = 64'd1 << FRAC_BITS;
        t     = 64'(r.phase[FRAC_BITS-1:0]);
        d     = 64'(r.duty);
        res   = '0;
        // Saturate duty to one
        if (d > one_v)
            d = one_v;
        case (r.req_type)
            SHAPE_SQUARE:
            begin
                span = r.use_duty ? d : (one_v >> 1);
                res  = (t < span) ? one_v : '0;
            end
            SHAPE_TRIANGLE:
            begin
                if (r.use_duty)
                begin
                    u  = (one_v - t) & (one_v - 1);
                    d2 = one_v - d;
                    if (d != 0 && t < d)
                        res += (t << FRAC_BITS) / d;
                    if (d2 != 0 && u < d2)
                        res += (u << FRAC_BITS) / d2;
                end
                else
                begin
                    twice = t << 1;
                    res   = (twice >= one_v) ? (twice - one_v) : (one_v - twice);
                end
            end
            SHAPE_SAWTOOTH:
            begin
                span = r.use_duty ? d : one_v;
                if (span == 0 || t > span)
                    res = '0;
                else if (t == 0 && span == one_v)
                    res = one_v;
                else
                    res = (t << FRAC_BITS) / span;
            end
            default:
                res = '0;
        endcase
        return res[OUT_W-1:0];
    endfunction

    function automatic wave_req_t mk_req(input logic [TYPE_W-1:0] kind, input logic dflag,
                                         input logic [PHASE_W-1:0] ph,
                                         input logic [DUTY_W-1:0] dy);
        wave_req_t r;
        r.req_type = kind;
        r.use_duty = dflag;
        r.phase    = ph;
        r.duty     = dy;
        return r;
    endfunction

    // Draw a request, biased toward duty edges and t near the duty
    function automatic wave_req_t rand_req();
        wave_req_t r;
        int        pick;
        pick       = $urandom_range(0, 99);
        r.req_type = (pick < 5) ? SHAPE_UNUSED : TYPE_W'($urandom_range(0, 2));
        r.use_duty = $urandom_range(0, 3) != 0;
        case ($urandom_range(0, 5))
            0:       r.duty = DUTY_W'($urandom_range(0, 3));
            1:       r.duty = DUTY_W'($urandom_range(65533, 65536));
            2:       r.duty = DUTY_W'($urandom_range(65537, 131071));
            default: r.duty = DUTY_W'($urandom_range(0, 65536));
        endcase
        r.phase = $urandom;
        case ($urandom_range(0, 7))
            0: r.phase[FRAC_BITS-1:0] = '0;
            1: r.phase[FRAC_BITS-1:0] = '1;
            2: r.phase[FRAC_BITS-1:0] = 16'h8000;
            3: r.phase[FRAC_BITS-1:0] = r.duty[FRAC_BITS-1:0] + 16'($urandom_range(0, 2)) - 16'd1;
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Send one request beat; returns at the falling edge after acceptance
    // ------------------------------------------------------------------------
    task automatic send_wave_req(input wave_req_t r);
        // Idle the request channel at random
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            req_bus.valid = 1'b0;
            @(negedge clk);
        end
        req_bus.req_type = r.req_type;
        req_bus.use_duty = r.use_duty;
        req_bus.phase    = r.phase;
        req_bus.duty     = r.duty;
        req_bus.valid    = 1'b1;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        pending_waves.push_back(calc_wave(r));
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_square_edges();
        send_wave_req(mk_req(SHAPE_SQUARE, 1'b0, 32'h0000_0000, 17'd0));
        send_wave_req(mk_req(SHAPE_SQUARE, 1'b0, 32'h0000_8000, 17'd0));
        send_wave_req(mk_req(SHAPE_SQUARE, 1'b0, 32'hFFFF_7FFF, 17'd0));
        send_wave_req(mk_req(SHAPE_SQUARE, 1'b1, 32'h0003_1000, 17'h01000));
        send_wave_req(mk_req(SHAPE_SQUARE, 1'b1, 32'h0000_0000, 17'd0));
        send_wave_req(mk_req(SHAPE_SQUARE, 1'b1, 32'h7FFF_FFFF, 17'h10000));
    endtask

    task automatic test_triangle_edges();
        send_wave_req(mk_req(SHAPE_TRIANGLE, 1'b0, 32'h8000_0000, 17'd0));
        send_wave_req(mk_req(SHAPE_TRIANGLE, 1'b0, 32'h0000_8000, 17'd0));
        send_wave_req(mk_req(SHAPE_TRIANGLE, 1'b0, 32'h0000_FFFF, 17'd0));
        send_wave_req(mk_req(SHAPE_TRIANGLE, 1'b1, 32'h0000_4000, 17'h08000));
        send_wave_req(mk_req(SHAPE_TRIANGLE, 1'b1, 32'hFFFF_C000, 17'h08000));
        send_wave_req(mk_req(SHAPE_TRIANGLE, 1'b1, 32'h0000_0000, 17'h08000));
        // Zero divisor on either term
        send_wave_req(mk_req(SHAPE_TRIANGLE, 1'b1, 32'h0000_0100, 17'd0));
        send_wave_req(mk_req(SHAPE_TRIANGLE, 1'b1, 32'h0000_0100, 17'h10000));
    endtask

    task automatic test_sawtooth_edges();
        send_wave_req(mk_req(SHAPE_SAWTOOTH, 1'b0, 32'h0001_0000, 17'd0));
        send_wave_req(mk_req(SHAPE_SAWTOOTH, 1'b0, 32'h0000_FFFF, 17'd0));
        send_wave_req(mk_req(SHAPE_SAWTOOTH, 1'b1, 32'h0000_1234, 17'd0));
        send_wave_req(mk_req(SHAPE_SAWTOOTH, 1'b1, 32'h0000_3001, 17'h03000));
        send_wave_req(mk_req(SHAPE_SAWTOOTH, 1'b1, 32'h0000_3000, 17'h03000));
    endtask

    task automatic test_saturation_and_unused();
        // Duty above one saturates
        send_wave_req(mk_req(SHAPE_SAWTOOTH, 1'b1, 32'h0000_0000, 17'h1FFFF));
        send_wave_req(mk_req(SHAPE_SQUARE, 1'b1, 32'h0000_FFFF, 17'h1FFFF));
        send_wave_req(mk_req(SHAPE_TRIANGLE, 1'b1, 32'h0000_2000, 17'h10001));
        // Unused shape code
        send_wave_req(mk_req(SHAPE_UNUSED, 1'b0, 32'h0000_4000, 17'h08000));
        send_wave_req(mk_req(SHAPE_UNUSED, 1'b1, 32'hFFFF_FFFF, 17'h1FFFF));
    endtask

    task automatic test_random_mix(input int count);
        repeat (count)
            send_wave_req(rand_req());
    endtask

    task automatic test_no_idle_stretch(input int count);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (count)
            send_wave_req(rand_req());
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
    endtask

    task automatic test_output_hold_off(input int count);
        // Hold the result channel while requests keep coming
        tx_idle_pct    = 0;
        rx_hold_cycles = HOLD_OFF_LEN;
        repeat (count)
            send_wave_req(rand_req());
        tx_idle_pct = IDLE_PCT;
    endtask

    // ------------------------------------------------------------------------
    // Result channel ready: hold-off, then random idling
    // ------------------------------------------------------------------------
    initial
    begin
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0)
            begin
                rsp_bus.ready  = 1'b0;
                rx_hold_cycles = rx_hold_cycles - 1;
            end
            else
                rsp_bus.ready = ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Score each result beat against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic [OUT_W-1:0] want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (pending_waves.size() == 0)
            begin
                $error("wave_value unexpected beat: expected none, actual %0d",
                       rsp_bus.wave_value);
                error_count++;
            end
            else
            begin
                want = pending_waves.pop_front();
                if (rsp_bus.wave_value !== want)
                begin
                    $error("wave_value mismatch: expected %0d, actual %0d",
                           want, rsp_bus.wave_value);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when no beat moves for too long
    // ------------------------------------------------------------------------
    initial
    begin
        int stall_count;
        stall_count = 0;
        while (stall_count < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                stall_count = 0;
            else
                stall_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int drain_count;
        rst_n            = 1'b0;
        req_bus.valid    = 1'b0;
        req_bus.req_type = '0;
        req_bus.use_duty = 1'b0;
        req_bus.phase    = '0;
        req_bus.duty     = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_square_edges();
        test_triangle_edges();
        test_sawtooth_edges();
        test_saturation_and_unused();
        test_random_mix(1000);
        test_no_idle_stretch(300);
        test_output_hold_off(100);
        test_random_mix(600);
        req_bus.valid = 1'b0;

        // Drain outstanding results, then let the pipeline settle
        drain_count = 0;
        while (pending_waves.size() != 0 && drain_count < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_count++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_waves.size() != 0)
        begin
            $error("wave_value missing: expected %0d more beats, actual 0",
                   pending_waves.size());
            error_count++;
        end

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
src/pwe_pkg.sv
src/pwe_in_if.sv
src/pwe_out_if.sv
src/pwe_front.sv
src/pwe_div_stage.sv
src/pwe_back.sv
src/periodic_waveform_eval_unit.sv
verif/periodic_waveform_eval_unit_tb.sv
